/* sv/ucd_pkg.sv */
// shared constants and axis codes for the up-axis change detector
`default_nettype none
package ucd_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_W          = 16;
	localparam int FRAC_W          = 16;
	localparam int AXIS_W          = 3;
	localparam int LANES           = 3;

	localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(1966);

	// up-axis codes: axis index times two, plus one for the negative side
	localparam logic [AXIS_W-1:0] AXIS_X_POS   = 3'd0;
	localparam logic [AXIS_W-1:0] AXIS_X_NEG   = 3'd1;
	localparam logic [AXIS_W-1:0] AXIS_Y_POS   = 3'd2;
	localparam logic [AXIS_W-1:0] AXIS_Y_NEG   = 3'd3;
	localparam logic [AXIS_W-1:0] AXIS_Z_POS   = 3'd4;
	localparam logic [AXIS_W-1:0] AXIS_Z_NEG   = 3'd5;
	localparam logic [AXIS_W-1:0] AXIS_UNKNOWN = 3'd6;

	function automatic logic [AXIS_W-1:0] axis_code(input logic [1:0] lane, input logic neg);
		logic [AXIS_W-1:0] code;
		case (lane)
			2'd0:    code = neg ? AXIS_X_NEG : AXIS_X_POS;
			2'd1:    code = neg ? AXIS_Y_NEG : AXIS_Y_POS;
			2'd2:    code = neg ? AXIS_Z_NEG : AXIS_Z_POS;
			default: code = AXIS_UNKNOWN;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

/* sv/ucd_lane.sv */
// one axis lane: first-order low-pass filter state and its update
`default_nettype none
module ucd_lane
	import ucd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             seed,
	input  wire logic signed [SAMPLE_BITS-1:0]    sample,
	input  wire logic        [COEF_W-1:0]         coef,
	output logic signed [SAMPLE_BITS+FRAC_W-1:0]  filt
);
	localparam int W = SAMPLE_BITS + FRAC_W;
	localparam int P = W + COEF_W + 2;

	logic signed [W-1:0] filt_q;
	logic signed [W:0]   diff;
	logic signed [P-1:0] prod;
	logic signed [P-1:0] biased;
	logic signed [W+1:0] step;
	logic signed [W+1:0] sum;
	logic signed [W-1:0] seed_val;

	assign seed_val = {sample, {FRAC_W{1'b0}}};

	// filt += round(diff * coef / 2^16), halves toward plus infinity
	assign diff   = {seed_val[W-1], seed_val} - {filt_q[W-1], filt_q};
	assign prod   = P'(diff) * $signed({1'b0, coef});
	assign biased = prod + P'(1 << (FRAC_W - 1));
	assign step   = biased[P-1:FRAC_W];
	assign sum    = {{2{filt_q[W-1]}}, filt_q} + step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (en) begin
			filt_q <= seed ? seed_val : sum[W-1:0];
		end
	end

	assign filt = filt_q;

endmodule
`default_nettype wire

/* sv/ucd_merge.sv */
// merge stage: largest filtered magnitude, stored axis and result register
`default_nettype none
module ucd_merge
	import ucd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        valid_s2,
	input  wire logic [LANES-1:0][SAMPLE_BITS+FRAC_W-1:0]    filt,
	output logic                                             go,
	output logic                                             out_valid,
	input  wire logic                                        out_ready,
	output logic [AXIS_W-1:0]                                up_axis
);
	localparam int W = SAMPLE_BITS + FRAC_W;

	logic [LANES-1:0][W-1:0] mag;
	logic [W-1:0]            best;
	logic [AXIS_W-1:0]       pick;
	logic [AXIS_W-1:0]       current_q;
	logic                    out_valid_q;
	logic [AXIS_W-1:0]       up_axis_q;
	logic                    changed;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag[i] = filt[i][W-1] ? W'(-filt[i]) : filt[i];
		end
	end

	// strict compare, earlier axis wins ties; all zero keeps stored code
	always_comb begin
		best = '0;
		pick = current_q;
		for (int i = 0; i < LANES; i++) begin
			if (mag[i] > best) begin
				best = mag[i];
				pick = axis_code(2'(i), filt[i][W-1]);
			end
		end
	end

	assign changed = pick != current_q;
	assign go      = valid_s2 && (!changed || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q   <= AXIS_UNKNOWN;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (go && changed) begin
				current_q   <= pick;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && changed) begin
			up_axis_q <= pick;
		end
	end

	assign out_valid = out_valid_q;
	assign up_axis   = up_axis_q;

endmodule
`default_nettype wire

/* sv/up_axis_change_detector_top.sv */
// top level of the up-axis change detector: three filter lanes and a merge stage
// an accepted request updates the lane filter registers; the merge stage registers its result (if any) from them
// throughput: one request per cycle while the merge stage does not stall, set by the filter update in each lane
// the lane multiply and add close the filter loop combinationally; the axis pick is a second stage
// a new request waits only while the merge stage holds a changed axis and the result is not taken
// reset (arst_n low, asynchronous): coefficient back to default, filters cleared, axis unknown
`default_nettype none
module up_axis_change_detector_top
	import ucd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration: low-pass coefficient, unsigned Q0.16
	input  wire logic                          cfg_we,
	input  wire logic [COEF_W-1:0]             cfg_wdata,
	// sample request channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] accel_x,
	input  wire logic signed [SAMPLE_BITS-1:0] accel_y,
	input  wire logic signed [SAMPLE_BITS-1:0] accel_z,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [AXIS_W-1:0]                  up_axis
);
	localparam int W = SAMPLE_BITS + FRAC_W;

	logic [COEF_W-1:0]             coef_q;
	logic                          seeded_q;
	logic                          valid_s2;
	logic                          in_fire;
	logic                          go;
	logic [LANES-1:0][W-1:0]       filt;
	logic signed [SAMPLE_BITS-1:0] samples [LANES];

	assign samples[0] = accel_x;
	assign samples[1] = accel_y;
	assign samples[2] = accel_z;

	// filter state may only move once the merge stage has read it
	assign in_ready = !valid_s2 || go;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (cfg_we) begin
			coef_q <= cfg_wdata;
		end
	end

	// first request only seeds the filters and never reaches the merge stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				seeded_q <= 1'b1;
			end
			if (in_ready) begin
				valid_s2 <= in_fire && seeded_q;
			end
		end
	end

	// one filter lane per axis
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		ucd_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (in_fire),
			.seed   (!seeded_q),
			.sample (samples[g]),
			.coef   (coef_q),
			.filt   (filt[g])
		);
	end

	// largest magnitude pick, change detect and result register
	ucd_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.filt      (filt),
		.go        (go),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.up_axis   (up_axis)
	);

endmodule
`default_nettype wire

/* sim/up_axis_change_detector_top_test.sv */
// self-checking testbench for the up-axis change detector top level
`timescale 1ns / 100ps
module up_axis_change_detector_top_test;
	import ucd_pkg::*;

	typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

	// sink behaviour, changed after a random span
	typedef enum logic [1:0] {
		SINK_STEADY,
		SINK_COIN,
		SINK_SPARSE,
		SINK_PERIODIC
	} sink_mode_t;

	// spare cycles after draining let requests with no result pass through the block
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;

	// axis codes by lane, positive and negative side
	localparam logic [AXIS_W-1:0] POS_CODE [3] = '{AXIS_X_POS, AXIS_Y_POS, AXIS_Z_POS};
	localparam logic [AXIS_W-1:0] NEG_CODE [3] = '{AXIS_X_NEG, AXIS_Y_NEG, AXIS_Z_NEG};

	// every input of the block known from time zero
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [COEF_W-1:0] cfg_wdata = '0;
	logic              in_valid  = 1'b0;
	sample_t           accel_x   = '0;
	sample_t           accel_y   = '0;
	sample_t           accel_z   = '0;
	logic              out_ready = 1'b1;
	logic              in_ready;
	logic              out_valid;
	logic [AXIS_W-1:0] up_axis;

	// orientation tracker: its own copy of the filters, the held axis and the coefficient
	longint            lowpass [3];
	logic [AXIS_W-1:0] held_axis;
	bit                filters_seeded;
	logic [COEF_W-1:0] coef_model;

	// axis codes still owed by the block, oldest first
	logic [AXIS_W-1:0] pending_up_axis [$];

	int         axis_changes = 0;
	int         fault_count  = 0;
	int         cycle_count  = 0;
	int         burst_left   = 0;
	int         sink_span    = 0;
	sink_mode_t sink_mode    = SINK_STEADY;
	logic [AXIS_W-1:0] owed_axis;

	up_axis_change_detector_top #(
		.SAMPLE_BITS(SAMPLE_BITS_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.accel_x  (accel_x),
		.accel_y  (accel_y),
		.accel_z  (accel_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.up_axis  (up_axis)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// low-pass update per lane, then the strictly largest magnitude picks the axis
	// ties go to the earlier lane; all-zero filters leave the held axis alone
	function automatic void track_orientation(input sample_t sx, input sample_t sy,
		input sample_t sz);
		longint            raw [3];
		longint            diff;
		longint            mag;
		longint            best;
		logic [AXIS_W-1:0] pick;
		int                i;
		raw[0] = sx;
		raw[1] = sy;
		raw[2] = sz;
		if (!filters_seeded) begin
			// first sample after reset loads the filters directly, nothing comes out
			for (i = 0; i < 3; i++)
				lowpass[i] = raw[i] * 65536;
			filters_seeded = 1'b1;
			return;
		end
		for (i = 0; i < 3; i++) begin
			diff = raw[i] * 65536 - lowpass[i];
			// rounded step, halves toward plus infinity
			lowpass[i] += (diff * longint'(coef_model) + 64'sd32768) >>> 16;
		end
		best = 0;
		pick = held_axis;
		for (i = 0; i < 3; i++) begin
			mag = (lowpass[i] < 0) ? -lowpass[i] : lowpass[i];
			if (mag > best) begin
				best = mag;
				pick = (lowpass[i] > 0) ? POS_CODE[i] : NEG_CODE[i];
			end
		end
		if (pick != held_axis) begin
			held_axis = pick;
			pending_up_axis.push_back(pick);
			axis_changes++;
		end
	endfunction

	function automatic void log_mismatch(input string what, input logic [AXIS_W-1:0] want,
		input logic [AXIS_W-1:0] got);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s: up_axis expected %0d, got %0d", $time, what, want, got);
	endfunction

	// result side: compare each taken result with the oldest owed code, plus the run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("up_axis_change_detector_top_test: FAIL");
			$finish;
		end else if (arst_n && out_valid && out_ready) begin
			if (pending_up_axis.size() == 0) begin
				log_mismatch("result with nothing owed", 'x, up_axis);
			end else begin
				owed_axis = pending_up_axis.pop_front();
				if (up_axis !== owed_axis)
					log_mismatch("wrong axis", owed_axis, up_axis);
			end
		end
	end

	// receiver back-pressure on a pattern of its own
	always @(negedge clk) begin
		if (sink_span == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_span = $urandom_range(20, 200);
		end
		sink_span--;
		case (sink_mode)
			SINK_STEADY: begin
				out_ready <= 1'b1;
			end
			SINK_COIN: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			SINK_SPARSE: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				// long stalls, with ready high only a quarter of the time in a repeating pattern
				out_ready <= ((sink_span % 16) < 4);
			end
		endcase
	end

	// one request, with the sender's bursts and gaps decided here
	task automatic send_sample(input sample_t sx, input sample_t sy, input sample_t sz);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		accel_x  <= sx;
		accel_y  <= sy;
		accel_z  <= sz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_orientation(sx, sy, sz);
	endtask

	// stop sending and wait until every owed result has been taken
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_up_axis.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// coefficient write, only ever with the block idle
	task automatic load_filter_coef(input logic [COEF_W-1:0] coef);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= coef;
		@(negedge clk);
		cfg_we     <= 1'b0;
		coef_model = coef;
	endtask

	// seed with zeros, zero filters hold the unknown axis, then the reset coefficient at work
	task automatic test_zero_filters();
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd0, 16'sd1);
		send_sample(16'sd0, 16'sd0, -16'sd1);
	endtask

	// with the coefficient at its top the filters follow almost at once: walk every axis code
	task automatic test_axis_codes();
		wait_drained();
		load_filter_coef(16'hFFFF);
		send_sample(16'sd32767, 16'sd0, 16'sd0);
		send_sample(16'sd32767, 16'sd0, 16'sd0);
		send_sample(-16'sd32768, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd32767, 16'sd0);
		send_sample(16'sd0, -16'sd32768, 16'sd0);
		send_sample(16'sd0, 16'sd0, 16'sd32767);
		send_sample(16'sd0, 16'sd0, -16'sd32768);
		// equal magnitudes on all lanes: x wins
		send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
		send_sample(16'sd32767, 16'sd32767, 16'sd32767);
		// back to zero filters, held axis kept
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd0, 16'sd0);
		// y and z tie, y wins
		send_sample(16'sd0, 16'sd5000, -16'sd5000);
	endtask

	// a zero coefficient freezes the filters, so no change can follow
	task automatic test_frozen_filter();
		int k;
		wait_drained();
		load_filter_coef('0);
		for (k = 0; k < 3; k++)
			send_sample(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
	endtask

	// runs of samples leaning on one axis, with noise requests and short broken runs mixed in
	task automatic run_orientation_phase(input logic [COEF_W-1:0] coef, input int n_items,
		input int min_changes);
		int      sent;
		int      first_changes;
		int      seg_len;
		int      code;
		int      lane;
		int      k;
		int      j;
		int      v;
		sample_t s [3];
		wait_drained();
		load_filter_coef(coef);
		sent = 0;
		first_changes = axis_changes;
		while (sent < n_items ||
			(axis_changes - first_changes < min_changes && sent < 4 * n_items)) begin
			code = $urandom_range(0, 5);
			lane = code / 2;
			seg_len = (coef >= 16'h2000) ? $urandom_range(1, 8) : $urandom_range(10, 90);
			if ($urandom_range(0, 9) == 0)
				seg_len = $urandom_range(1, 3);
			for (k = 0; k < seg_len; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					for (j = 0; j < 3; j++)
						s[j] = sample_t'($urandom);
				end else begin
					for (j = 0; j < 3; j++) begin
						v    = $urandom_range(0, 12000) - 6000;
						s[j] = sample_t'(v);
					end
					v = $urandom_range(8000, 32767);
					if (code % 2 == 1)
						v = -v - $urandom_range(0, 1);
					s[lane] = sample_t'(v);
				end
				send_sample(s[0], s[1], s[2]);
				sent++;
				// halfway through, let everything owed come out before going on
				if (sent == n_items / 2)
					wait_drained();
			end
		end
	endtask

	task automatic test_random_orientation();
		run_orientation_phase(COEF_RESET, 400, 4);
		run_orientation_phase(16'hFFFF, 300, 40);
		run_orientation_phase(16'h8000, 250, 20);
		run_orientation_phase(COEF_W'($urandom_range(2048, 65535)), 250, 0);
		run_orientation_phase(16'h0001, 60, 0);
		run_orientation_phase(16'h0800, 240, 0);
	endtask

	initial begin
		lowpass[0]     = 0;
		lowpass[1]     = 0;
		lowpass[2]     = 0;
		held_axis      = AXIS_UNKNOWN;
		filters_seeded = 1'b0;
		coef_model     = COEF_RESET;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_zero_filters();
		test_axis_codes();
		test_frozen_filter();
		test_random_orientation();
		wait_drained();

		if (fault_count == 0) begin
			$display("up_axis_change_detector_top_test: PASS");
		end else begin
			$display("up_axis_change_detector_top_test: FAIL");
		end
		$finish;
	end

endmodule
